[rtl/cpsb_pkg.sv]
// ----------------------------------------------------------------------------
// cpsb_pkg: shared types and codes for the code point set bitmap
// Opcodes, sequencer states and the control word passed to the word unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cpsb_pkg;

   localparam int OPCODE_BITS = 3;

   localparam logic [OPCODE_BITS-1:0] OP_QUERY   = 3'd0;
   localparam logic [OPCODE_BITS-1:0] OP_ADD_PT  = 3'd1;
   localparam logic [OPCODE_BITS-1:0] OP_DEL_PT  = 3'd2;
   localparam logic [OPCODE_BITS-1:0] OP_ADD_RNG = 3'd3;
   localparam logic [OPCODE_BITS-1:0] OP_DEL_RNG = 3'd4;
   localparam logic [OPCODE_BITS-1:0] OP_FILL    = 3'd5;
   localparam logic [OPCODE_BITS-1:0] OP_CLEAR   = 3'd6;

   typedef enum logic [3:0] {
      ST_INIT,       // post-reset clearing pass
      ST_IDLE,
      ST_SPL_A,      // feed start point into splitter
      ST_SPL_B,      // feed end point into splitter
      ST_SPL_C,      // capture start word / bit
      ST_SPL_D,      // capture end word / bit, dispatch
      ST_WALK_RD,    // read one word of a range
      ST_WALK_WR,    // write it back with the mask applied
      ST_WR_ALL,     // fill / clear sweep
      ST_RD,         // read word holding code point
      ST_LOOK        // pick result bit, load output register
   } state_type;

   typedef struct packed {
      logic set;     // 1 sets masked bits, 0 clears them
      logic full;    // whole word is masked
      logic first;   // word holds range start
      logic last;    // word holds range end
   } word_ctl_type;

endpackage

`default_nettype wire

[rtl/cpsb_mem.sv]
// ----------------------------------------------------------------------------
// cpsb_mem: bitmap word store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsb_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 64
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] words_mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         words_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= words_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/cpsb_split.sv]
// ----------------------------------------------------------------------------
// cpsb_split: point to word index / bit offset
// Two-stage divide by WORD_BITS via reciprocal multiply; new operand each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsb_split #(
   parameter int CODE_BITS = 16,
   parameter int WORD_BITS = 64
) (
   input  wire logic                                clock,
   input  wire logic [CODE_BITS-1:0]                point,
   output logic      [$clog2((2**CODE_BITS + WORD_BITS - 1) / WORD_BITS)-1:0] word_idx,
   output logic      [$clog2(WORD_BITS)-1:0]        bit_idx
);

   localparam int NUM_WORDS = (2**CODE_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WI        = $clog2(NUM_WORDS);
   localparam int BI        = $clog2(WORD_BITS);
   // exact for every point below 2**CODE_BITS since 2**6 >= WORD_BITS
   localparam int SHIFT     = CODE_BITS + 6;
   localparam longint RECIP = (64'(1) << SHIFT) / WORD_BITS + 1;
   localparam int MW        = $clog2(RECIP + 1);
   localparam int PW        = CODE_BITS + MW;
   localparam logic [MW-1:0]        RECIP_V = MW'(RECIP);
   localparam logic [CODE_BITS-1:0] WB_V    = CODE_BITS'(WORD_BITS);

   logic [PW-1:0]        prod;
   logic [CODE_BITS-1:0] p_ff;
   logic [WI-1:0]        q_ff;
   logic [CODE_BITS-1:0] base;
   logic [WI-1:0]        word_ff;
   logic [BI-1:0]        bit_ff;

   assign prod = PW'(point) * PW'(RECIP_V);

   always_ff @(posedge clock) begin
      p_ff <= point;
      q_ff <= WI'(prod >> SHIFT);
   end

   assign base = CODE_BITS'(CODE_BITS'(q_ff) * WB_V);

   always_ff @(posedge clock) begin
      word_ff <= q_ff;
      bit_ff  <= BI'(p_ff - base);
   end

   assign word_idx = word_ff;
   assign bit_idx  = bit_ff;

endmodule

`default_nettype wire

[rtl/cpsb_word_unit.sv]
// ----------------------------------------------------------------------------
// cpsb_word_unit: masked set / clear of one bitmap word
// Builds the bit mask for the current word of a walk and applies it.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsb_word_unit #(
   parameter int WORD_BITS = 64
) (
   input  wire cpsb_pkg::word_ctl_type          ctl,
   input  wire logic [$clog2(WORD_BITS)-1:0]    lo_bit,
   input  wire logic [$clog2(WORD_BITS)-1:0]    hi_bit,
   input  wire logic [WORD_BITS-1:0]            old_word,
   output logic      [WORD_BITS-1:0]            new_word
);

   localparam int BI = $clog2(WORD_BITS);

   logic [WORD_BITS-1:0] mask;

   always_comb begin
      mask = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         mask[i] = ctl.full
                 | ((!ctl.first || (BI'(i) >= lo_bit)) && (!ctl.last || (BI'(i) <= hi_bit)));
      end
   end

   assign new_word = ctl.set ? (old_word | mask) : (old_word & ~mask);

endmodule

`default_nettype wire

[rtl/code_point_set_bitmap.sv]
// ----------------------------------------------------------------------------
// code_point_set_bitmap: membership set over all code points
// Bitmap of 2**CODE_BITS bits in WORD_BITS-wide words, driven by a sequencer.
// ----------------------------------------------------------------------------
// Each request word carries an opcode (query, add/remove point, add/remove
// inclusive range, fill, clear), a code point and a range end; each gives one
// response word telling whether the code point is a member after the update.
// One request is in flight at a time; req_ready is low while it is worked.
// The bitmap has one read and one write port, so a range walk reads each
// word and then writes it back with the mask applied. After reset the block
// sweeps zeros through all N = 2**CODE_BITS/WORD_BITS words (N = 1024 by
// default) before raising req_ready.
// A pending response sits in an output register, so a new request can be
// taken while the last response is still waiting. Reversed ranges change
// nothing; opcode 7 acts as a query.
// ----------------------------------------------------------------------------
`default_nettype none

module code_point_set_bitmap #(
   parameter int CODE_BITS = 16,
   parameter int WORD_BITS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [15:0] req_code_point,
   input  wire logic [15:0] req_range_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_is_member
);

   localparam int NUM_WORDS = (2**CODE_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WI        = $clog2(NUM_WORDS);
   localparam int BI        = $clog2(WORD_BITS);
   localparam logic [WI-1:0] LAST_WORD = WI'(NUM_WORDS - 1);

   cpsb_pkg::state_type state_ff, state_in;

   logic [2:0]           op_ff, op_in;
   logic [CODE_BITS-1:0] cp_ff, cp_in;
   logic [CODE_BITS-1:0] re_ff, re_in;
   logic [WI-1:0]        wlo_ff, wlo_in;      // word of code point / range start
   logic [BI-1:0]        lo_bit_ff, lo_bit_in;
   logic [WI-1:0]        whi_ff, whi_in;
   logic [BI-1:0]        hi_bit_ff, hi_bit_in;
   logic [WI-1:0]        addr_ff, addr_in;    // walk / sweep pointer
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_is_member_ff, rsp_is_member_in;

   logic [CODE_BITS-1:0] split_pt;
   logic [WI-1:0]        split_word;
   logic [BI-1:0]        split_bit;

   logic                 mem_we;
   logic [WI-1:0]        mem_raddr;
   logic [WORD_BITS-1:0] mem_rdata;
   logic [WORD_BITS-1:0] mem_wdata;

   cpsb_pkg::word_ctl_type wctl;

   logic accept;
   logic out_free;
   logic is_point_op;
   logic range_ok;

   assign accept      = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign is_point_op = (req_opcode == cpsb_pkg::OP_ADD_PT)
                     || (req_opcode == cpsb_pkg::OP_DEL_PT);
   assign range_ok    = (re_ff >= cp_ff);

   // ---------------------------------------------------------------------
   // Shared units
   // ---------------------------------------------------------------------
   // splitter is pipelined: start point fed in SPL_A, end point in SPL_B,
   // results come out of its registers in SPL_C and SPL_D
   assign split_pt = (state_ff == cpsb_pkg::ST_SPL_B) ? re_ff : cp_ff;

   cpsb_split #(
      .CODE_BITS (CODE_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_split (
      .clock    (clock),
      .point    (split_pt),
      .word_idx (split_word),
      .bit_idx  (split_bit)
   );

   cpsb_word_unit #(
      .WORD_BITS (WORD_BITS)
   ) u_word (
      .ctl      (wctl),
      .lo_bit   (lo_bit_ff),
      .hi_bit   (hi_bit_ff),
      .old_word (mem_rdata),
      .new_word (mem_wdata)
   );

   cpsb_mem #(
      .DEPTH (NUM_WORDS),
      .AW    (WI),
      .DW    (WORD_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (addr_ff),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cpsb_pkg::ST_INIT: begin
            if (addr_ff == LAST_WORD) begin
               state_in = cpsb_pkg::ST_IDLE;
            end
         end
         cpsb_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = cpsb_pkg::ST_SPL_A;
            end
         end
         cpsb_pkg::ST_SPL_A: state_in = cpsb_pkg::ST_SPL_B;
         cpsb_pkg::ST_SPL_B: state_in = cpsb_pkg::ST_SPL_C;
         cpsb_pkg::ST_SPL_C: state_in = cpsb_pkg::ST_SPL_D;
         cpsb_pkg::ST_SPL_D: begin
            case (op_ff) inside
               cpsb_pkg::OP_FILL, cpsb_pkg::OP_CLEAR:
                  state_in = cpsb_pkg::ST_WR_ALL;
               cpsb_pkg::OP_ADD_PT, cpsb_pkg::OP_DEL_PT,
               cpsb_pkg::OP_ADD_RNG, cpsb_pkg::OP_DEL_RNG:
                  state_in = range_ok ? cpsb_pkg::ST_WALK_RD : cpsb_pkg::ST_RD;
               default:
                  state_in = cpsb_pkg::ST_RD;
            endcase
         end
         cpsb_pkg::ST_WALK_RD: state_in = cpsb_pkg::ST_WALK_WR;
         cpsb_pkg::ST_WALK_WR: begin
            state_in = (addr_ff == whi_ff) ? cpsb_pkg::ST_RD : cpsb_pkg::ST_WALK_RD;
         end
         cpsb_pkg::ST_WR_ALL: begin
            if (addr_ff == LAST_WORD) begin
               state_in = cpsb_pkg::ST_RD;
            end
         end
         cpsb_pkg::ST_RD: state_in = cpsb_pkg::ST_LOOK;
         cpsb_pkg::ST_LOOK: begin
            if (out_free) begin
               state_in = cpsb_pkg::ST_IDLE;
            end
         end
         default: state_in = cpsb_pkg::ST_INIT;
      endcase
   end

   // ---------------------------------------------------------------------
   // Outputs and datapath control
   // ---------------------------------------------------------------------
   always_comb begin
      req_ready        = 1'b0;
      mem_we           = 1'b0;
      mem_raddr        = wlo_ff;
      wctl.set         = 1'b0;
      wctl.full        = 1'b0;
      wctl.first       = (addr_ff == wlo_ff);
      wctl.last        = (addr_ff == whi_ff);
      op_in            = op_ff;
      cp_in            = cp_ff;
      re_in            = re_ff;
      wlo_in           = wlo_ff;
      lo_bit_in        = lo_bit_ff;
      whi_in           = whi_ff;
      hi_bit_in        = hi_bit_ff;
      addr_in          = addr_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_is_member_in = rsp_is_member_ff;

      if (state_ff != cpsb_pkg::ST_INIT) begin
         case (op_ff) inside
            cpsb_pkg::OP_ADD_PT, cpsb_pkg::OP_ADD_RNG, cpsb_pkg::OP_FILL:
               wctl.set = 1'b1;
            default:
               wctl.set = 1'b0;
         endcase
      end

      unique case (state_ff)
         cpsb_pkg::ST_INIT: begin
            wctl.full = 1'b1;
            mem_we    = 1'b1;
            addr_in   = (addr_ff == LAST_WORD) ? '0 : addr_ff + 1'b1;
         end
         cpsb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               op_in = req_opcode;
               cp_in = CODE_BITS'(req_code_point);
               // single point updates are ranges of one point
               re_in = is_point_op ? CODE_BITS'(req_code_point)
                                   : CODE_BITS'(req_range_end);
            end
         end
         cpsb_pkg::ST_SPL_A, cpsb_pkg::ST_SPL_B: begin
         end
         cpsb_pkg::ST_SPL_C: begin
            wlo_in    = split_word;
            lo_bit_in = split_bit;
         end
         cpsb_pkg::ST_SPL_D: begin
            whi_in    = split_word;
            hi_bit_in = split_bit;
            case (op_ff) inside
               cpsb_pkg::OP_FILL, cpsb_pkg::OP_CLEAR: addr_in = '0;
               default:                               addr_in = wlo_ff;
            endcase
         end
         cpsb_pkg::ST_WALK_RD: begin
            mem_raddr = addr_ff;
         end
         cpsb_pkg::ST_WALK_WR: begin
            mem_we  = 1'b1;
            addr_in = addr_ff + 1'b1;
         end
         cpsb_pkg::ST_WR_ALL: begin
            wctl.full = 1'b1;
            mem_we    = 1'b1;
            addr_in   = (addr_ff == LAST_WORD) ? '0 : addr_ff + 1'b1;
         end
         cpsb_pkg::ST_RD: begin
         end
         cpsb_pkg::ST_LOOK: begin
            // read address stays on the code point's word, so data holds
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_is_member_in = mem_rdata[lo_bit_ff];
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpsb_pkg::ST_INIT;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      cp_ff            <= cp_in;
      re_ff            <= re_in;
      wlo_ff           <= wlo_in;
      lo_bit_ff        <= lo_bit_in;
      whi_ff           <= whi_in;
      hi_bit_ff        <= hi_bit_in;
      rsp_is_member_ff <= rsp_is_member_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_is_member = rsp_is_member_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cpsb_pkg::ST_IDLE || state_ff == cpsb_pkg::ST_LOOK
       || state_ff == cpsb_pkg::ST_RD) |-> !mem_we)
      else $error("bitmap written outside an update");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in flight");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cpsb_pkg::ST_WALK_WR) |-> (addr_ff >= wlo_ff && addr_ff <= whi_ff))
      else $error("range walk left its word span");

   a_rsp_from_look: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == cpsb_pkg::ST_LOOK)
      else $error("response raised outside lookup");

   a_look_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cpsb_pkg::ST_LOOK && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("free output register not loaded");

endmodule

`default_nettype wire
